// ===== design/nlss_pkg.sv =====
// ---------------------------------------------------------------------------
// nlss_pkg: shared types and constants of the batch scheduler
// Field widths, payload structs, the memory entry, controller states and the
// control bundle between the controller and the selection unit.
// ---------------------------------------------------------------------------
package nlss_pkg;

   localparam int ARR_W  = 16;
   localparam int BUR_W  = 16;
   localparam int TIME_W = 23;
   localparam int SUM_W  = 29;
   localparam int PNUM_W = 7;

   typedef struct packed {
      logic [ARR_W-1:0] arrival_time;
      logic [BUR_W-1:0] burst_time;
      logic             last_process;
   } req_type;

   typedef struct packed {
      logic [PNUM_W-1:0] process_number;
      logic [TIME_W-1:0] wait_time;
      logic [TIME_W-1:0] turnaround_time;
      logic [SUM_W-1:0]  total_wait;
      logic [SUM_W-1:0]  total_turnaround;
      logic              last_result;
   } rsp_type;

   typedef struct packed {
      logic [ARR_W-1:0] arrival;
      logic [BUR_W-1:0] burst;
      logic             done;  // set once the process has run in this batch
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;  // start a new pass over the stored processes
      logic valid;  // an entry read from the store arrives this cycle
   } pick_ctrl_type;

endpackage

// ===== design/nlss_store.sv =====
// ---------------------------------------------------------------------------
// nlss_store: process table
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module nlss_store #(
   parameter int DEPTH = 64,
   parameter int IDX_W = 6
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  nlss_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output nlss_pkg::entry_type rd_data
);

   nlss_pkg::entry_type mem_ff [DEPTH];
   nlss_pkg::entry_type rd_data_ff;

   // write one entry when enabled: a loaded process or a finish-mark write-back
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read during the scan
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/nlss_pick.sv =====
// ---------------------------------------------------------------------------
// nlss_pick: selection unit
// Sees one stored process per cycle during a pass and keeps the best ready
// candidate under the active policy and the earliest pending arrival.
// ---------------------------------------------------------------------------
module nlss_pick #(
   parameter int IDX_W = 6
) (
   input  logic                             clock,
   input  logic                             reset,
   input  nlss_pkg::pick_ctrl_type          ctrl,
   input  logic [IDX_W-1:0]                 entry_idx,
   input  nlss_pkg::entry_type              entry,
   input  logic                             entry_done,
   input  logic [nlss_pkg::TIME_W-1:0]      cur_time,
   input  logic                             policy,
   output logic                             found,
   output logic [IDX_W-1:0]                 best_idx,
   output logic [nlss_pkg::ARR_W-1:0]       best_arrival,
   output logic [nlss_pkg::BUR_W-1:0]       best_burst,
   output logic [nlss_pkg::ARR_W-1:0]       min_arrival
);

   logic                       found_ff, found_in;
   logic [IDX_W-1:0]           best_idx_ff, best_idx_in;
   logic [nlss_pkg::ARR_W-1:0] best_arr_ff, best_arr_in;
   logic [nlss_pkg::BUR_W-1:0] best_bur_ff, best_bur_in;
   logic [nlss_pkg::ARR_W-1:0] min_arr_ff, min_arr_in;
   logic                       ready;
   logic                       better;

   // compare the arriving entry with the held candidate
   always_comb begin
      ready = !entry_done && (nlss_pkg::TIME_W'(entry.arrival) <= cur_time);
      if (!policy) begin
         better = entry.arrival > best_arr_ff;
      end else begin
         better = (entry.burst < best_bur_ff) ||
                  ((entry.burst == best_bur_ff) && (entry.arrival < best_arr_ff));
      end

      found_in    = found_ff;
      best_idx_in = best_idx_ff;
      best_arr_in = best_arr_ff;
      best_bur_in = best_bur_ff;
      min_arr_in  = min_arr_ff;

      if (ctrl.clear) begin
         found_in   = 1'b0;
         min_arr_in = '1;
      end else if (ctrl.valid) begin
         if (ready && (!found_ff || better)) begin
            found_in    = 1'b1;
            best_idx_in = entry_idx;
            best_arr_in = entry.arrival;
            best_bur_in = entry.burst;
         end
         if (!entry_done && (entry.arrival < min_arr_ff)) begin
            min_arr_in = entry.arrival;
         end
      end
   end

   // hold the candidate between entries
   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff   <= 1'b0;
         min_arr_ff <= '1;
      end else begin
         found_ff   <= found_in;
         min_arr_ff <= min_arr_in;
      end
      best_idx_ff <= best_idx_in;
      best_arr_ff <= best_arr_in;
      best_bur_ff <= best_bur_in;
   end

   assign found        = found_ff;
   assign best_idx     = best_idx_ff;
   assign best_arrival = best_arr_ff;
   assign best_burst   = best_bur_ff;
   assign min_arrival  = min_arr_ff;

endmodule

// ===== design/nonpreemptive_lcfs_sjf_scheduler.sv =====
// Loading: one process per cycle; req_stall is low while no batch is running.
// Each selection scans the n stored processes through the table read port,
// and scans them again after a time jump; emission waits while rsp_stall holds.
// Synchronous active-high reset clears the counters, policy and result valid;
// the table is not cleared, a finish mark is cleared as its entry is loaded.
// ---------------------------------------------------------------------------
// nonpreemptive_lcfs_sjf_scheduler: batch LCFS / SJF scheduler
// Stores a batch of processes, then replays non-preemptive scheduling and
// emits number, wait and turnaround time per process, totals on the last.
// ---------------------------------------------------------------------------
module nonpreemptive_lcfs_sjf_scheduler #(
   parameter int MAX_PROCESSES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nlss_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nlss_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
   localparam int TW    = nlss_pkg::TIME_W;
   localparam int SW    = nlss_pkg::SUM_W;

   nlss_pkg::state_type       state_ff, state_in;
   logic                      policy_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [CNT_W-1:0]          done_ff, done_in;
   logic [CNT_W-1:0]          issue_ff, issue_in;
   logic                      rd_valid_ff, rd_valid_in;
   logic [IDX_W-1:0]          rd_idx_ff, rd_idx_in;
   logic [TW-1:0]             cur_time_ff, cur_time_in;
   logic [SW-1:0]             wait_sum_ff, wait_sum_in;
   logic [SW-1:0]             tat_sum_ff, tat_sum_in;
   logic [TW-1:0]             wait_ff, wait_in;
   logic [TW-1:0]             tat_ff, tat_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   nlss_pkg::rsp_type         rsp_data_ff, rsp_data_in;

   logic                      mem_wr_en;
   logic                      mem_rd_en;
   logic [IDX_W-1:0]          mem_wr_addr;
   nlss_pkg::entry_type       mem_wr_data;
   nlss_pkg::entry_type       mem_rd_data;
   nlss_pkg::pick_ctrl_type   pick_ctrl;
   logic                      pick_found;
   logic [IDX_W-1:0]          pick_idx;
   logic [nlss_pkg::ARR_W-1:0] pick_arr;
   logic [nlss_pkg::BUR_W-1:0] pick_bur;
   logic [nlss_pkg::ARR_W-1:0] pick_min;
   logic                      slot_free;
   logic [CNT_W-1:0]          done_next;
   logic                      is_last;
   logic [SW-1:0]             wait_total;
   logic [SW-1:0]             tat_total;

   // process table; the finish mark is written back in the cycle before the
   // next pass starts reading, so reads and writes never meet on one entry
   nlss_store #(
      .DEPTH (MAX_PROCESSES),
      .IDX_W (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (mem_rd_data)
   );

   // candidate selection over one pass
   nlss_pick #(
      .IDX_W (IDX_W)
   ) u_pick (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (pick_ctrl),
      .entry_idx    (rd_idx_ff),
      .entry        (mem_rd_data),
      .entry_done   (mem_rd_data.done),
      .cur_time     (cur_time_ff),
      .policy       (policy_ff),
      .found        (pick_found),
      .best_idx     (pick_idx),
      .best_arrival (pick_arr),
      .best_burst   (pick_bur),
      .min_arrival  (pick_min)
   );

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign done_next  = done_ff + CNT_W'(1);
   assign is_last    = (done_next == count_ff);
   assign wait_total = wait_sum_ff + SW'(wait_ff);
   assign tat_total  = tat_sum_ff + SW'(tat_ff);

   // next state and datapath control
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      done_in     = done_ff;
      issue_in    = issue_ff;
      rd_valid_in = 1'b0;
      rd_idx_in   = rd_idx_ff;
      cur_time_in = cur_time_ff;
      wait_sum_in = wait_sum_ff;
      tat_sum_in  = tat_sum_ff;
      wait_in     = wait_ff;
      tat_in      = tat_ff;
      rsp_data_in = rsp_data_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      mem_wr_addr = count_ff[IDX_W-1:0];
      mem_wr_data.arrival = req_data.arrival_time;
      mem_wr_data.burst   = req_data.burst_time;
      mem_wr_data.done    = 1'b0;
      pick_ctrl   = '0;
      pick_ctrl.valid = rd_valid_ff;
      req_stall   = (state_ff != nlss_pkg::ST_IDLE);

      // drop the result once taken
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         nlss_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (count_ff < CNT_W'(MAX_PROCESSES)) begin
                  mem_wr_en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end
               if (req_data.last_process) begin
                  issue_in        = '0;
                  done_in         = '0;
                  pick_ctrl.clear = 1'b1;
                  state_in        = nlss_pkg::ST_SCAN;
               end
            end
         end
         nlss_pkg::ST_SCAN: begin
            if (issue_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               rd_valid_in = 1'b1;
               rd_idx_in   = issue_ff[IDX_W-1:0];
               issue_in    = issue_ff + CNT_W'(1);
            end else if (!rd_valid_ff) begin
               state_in = nlss_pkg::ST_DECIDE;
            end
         end
         nlss_pkg::ST_DECIDE: begin
            if (pick_found) begin
               wait_in  = cur_time_ff - TW'(pick_arr);
               tat_in   = wait_in + TW'(pick_bur);
               state_in = nlss_pkg::ST_EMIT;
            end else begin
               // nothing ready: jump to the earliest pending arrival, rescan
               cur_time_in     = TW'(pick_min);
               issue_in        = '0;
               pick_ctrl.clear = 1'b1;
               state_in        = nlss_pkg::ST_SCAN;
            end
         end
         nlss_pkg::ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.process_number   = nlss_pkg::PNUM_W'(pick_idx) +
                                              nlss_pkg::PNUM_W'(1);
               rsp_data_in.wait_time        = wait_ff;
               rsp_data_in.turnaround_time  = tat_ff;
               rsp_data_in.total_wait       = is_last ? wait_total : '0;
               rsp_data_in.total_turnaround = is_last ? tat_total : '0;
               rsp_data_in.last_result      = is_last;
               if (is_last) begin
                  // batch complete: return to an empty table
                  count_in    = '0;
                  done_in     = '0;
                  cur_time_in = '0;
                  wait_sum_in = '0;
                  tat_sum_in  = '0;
                  state_in    = nlss_pkg::ST_IDLE;
               end else begin
                  // write back the entry with its finish mark set
                  mem_wr_en           = 1'b1;
                  mem_wr_addr         = pick_idx;
                  mem_wr_data.arrival = pick_arr;
                  mem_wr_data.burst   = pick_bur;
                  mem_wr_data.done    = 1'b1;
                  done_in         = done_next;
                  cur_time_in     = cur_time_ff + TW'(pick_bur);
                  wait_sum_in     = wait_total;
                  tat_sum_in      = tat_total;
                  issue_in        = '0;
                  pick_ctrl.clear = 1'b1;
                  state_in        = nlss_pkg::ST_SCAN;
               end
            end
         end
         default: begin
            state_in = nlss_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= nlss_pkg::ST_IDLE;
         policy_ff    <= 1'b0;
         count_ff     <= '0;
         done_ff      <= '0;
         issue_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         cur_time_ff  <= '0;
         wait_sum_ff  <= '0;
         tat_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            policy_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         done_ff      <= done_in;
         issue_ff     <= issue_in;
         rd_valid_ff  <= rd_valid_in;
         cur_time_ff  <= cur_time_in;
         wait_sum_ff  <= wait_sum_in;
         tat_sum_ff   <= tat_sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      wait_ff     <= wait_in;
      tat_ff      <= tat_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // fewer processes finished than loaded while a batch runs
   a_done_below_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff != nlss_pkg::ST_IDLE) |-> (done_ff < count_ff))
      else $error("finished count reached loaded count inside a batch");

   // an idle processor only ever jumps forward in time
   a_jump_forward: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == nlss_pkg::ST_DECIDE) && !pick_found)
         |-> (TW'(pick_min) > cur_time_ff))
      else $error("time jump does not move forward");

   // a selected process has already arrived
   a_pick_arrived: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == nlss_pkg::ST_DECIDE) && pick_found)
         |-> (TW'(pick_arr) <= cur_time_ff))
      else $error("process selected before its arrival");

   // the final transfer of a batch empties the table
   a_batch_close: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == nlss_pkg::ST_EMIT) && slot_free && is_last)
         |=> ((state_ff == nlss_pkg::ST_IDLE) && (count_ff == '0) && rsp_valid_ff
              && rsp_data_ff.last_result))
      else $error("batch not closed after final result");

endmodule

// ===== tb/nonpreemptive_lcfs_sjf_scheduler_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// nonpreemptive_lcfs_sjf_scheduler_test: batch scheduler testbench
// Loads batches of processes under both selection policies. A scoreboard
// replays the schedule of each closed batch and checks every emitted
// process result in order, totals included. The request channel idles and
// the result channel stalls in random bursts.
// ---------------------------------------------------------------------------
module nonpreemptive_lcfs_sjf_scheduler_test;

   localparam int MAX_PROCS     = 64;
   localparam int RANDOM_ITEMS  = 380;
   localparam int QUIET_ITEMS   = 60;
   localparam int SETTLE_CYCLES = 16;
   localparam int LIMIT_CYCLES  = 600000;

   // Replays non-preemptive scheduling of each batch and holds the results
   class sched_scoreboard;
      bit                shortest_first;
      logic [15:0]       arrival_mem [MAX_PROCS];
      logic [15:0]       burst_mem   [MAX_PROCS];
      bit                finished    [MAX_PROCS];
      int                stored;
      int unsigned       clock_now;
      nlss_pkg::rsp_type expected_runs [$];
      int                mismatches;

      // Index of the process to run at clock_now, or -1 if none has arrived
      function int pick_next();
         int best;
         best = -1;
         for (int i = 0; i < stored; i++) begin
            if (finished[i] || arrival_mem[i] > clock_now) continue;
            if (best < 0) begin
               best = i;
            end else if (!shortest_first) begin
               if (arrival_mem[i] > arrival_mem[best]) best = i;
            end else if (burst_mem[i] < burst_mem[best] ||
                         (burst_mem[i] == burst_mem[best] &&
                          arrival_mem[i] < arrival_mem[best])) begin
               best = i;
            end
         end
         return best;
      endfunction

      function void note_request(nlss_pkg::req_type item);
         int                sel;
         int unsigned       wait_t;
         int unsigned       turn_t;
         int unsigned       wait_total;
         int unsigned       turn_total;
         int unsigned       earliest;
         nlss_pkg::rsp_type run;
         // Store unless the table is full; drop the item otherwise
         if (stored < MAX_PROCS) begin
            arrival_mem[stored] = item.arrival_time;
            burst_mem[stored]   = item.burst_time;
            finished[stored]    = 1'b0;
            stored++;
         end
         if (!item.last_process) return;
         clock_now  = 0;
         wait_total = 0;
         turn_total = 0;
         for (int k = 0; k < stored; k++) begin
            sel = pick_next();
            // Jump the clock to the earliest pending arrival when idle
            if (sel < 0) begin
               earliest = 16'hFFFF;
               for (int i = 0; i < stored; i++)
                  if (!finished[i] && arrival_mem[i] < earliest) earliest = arrival_mem[i];
               clock_now = earliest;
               sel = pick_next();
            end
            wait_t     = clock_now - arrival_mem[sel];
            turn_t     = wait_t + burst_mem[sel];
            wait_total += wait_t;
            turn_total += turn_t;
            clock_now  += burst_mem[sel];
            finished[sel] = 1'b1;
            run = '0;
            run.process_number  = nlss_pkg::PNUM_W'(sel + 1);
            run.wait_time       = nlss_pkg::TIME_W'(wait_t);
            run.turnaround_time = nlss_pkg::TIME_W'(turn_t);
            if (k == stored - 1) begin
               run.total_wait       = nlss_pkg::SUM_W'(wait_total);
               run.total_turnaround = nlss_pkg::SUM_W'(turn_total);
               run.last_result      = 1'b1;
            end
            expected_runs = {expected_runs, run};
         end
         stored = 0;
      endfunction

      function void check_result(nlss_pkg::rsp_type got);
         nlss_pkg::rsp_type want;
         if (expected_runs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: process %0d wait %0d turnaround %0d",
                        got.process_number, got.wait_time, got.turnaround_time);
            return;
         end
         want = expected_runs.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"result mismatch (expected/actual): process %0d/%0d ",
                         "wait %0d/%0d turnaround %0d/%0d total_wait %0d/%0d ",
                         "total_turnaround %0d/%0d last %0d/%0d"},
                        want.process_number, got.process_number,
                        want.wait_time, got.wait_time,
                        want.turnaround_time, got.turnaround_time,
                        want.total_wait, got.total_wait,
                        want.total_turnaround, got.total_turnaround,
                        want.last_result, got.last_result);
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   nlss_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   nlss_pkg::rsp_type rsp_data;
   logic              csr_wr_en;
   logic              csr_wr_data;

   sched_scoreboard board = new();
   bit              quiet = 1'b0;
   int              stall_hold = 0;
   int              cycle_count = 0;

   nonpreemptive_lcfs_sjf_scheduler #(
      .MAX_PROCESSES(MAX_PROCS)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Generate the 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Stall the result channel in random bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_stall  <= 1'b1;
         stall_hold <= $urandom_range(0, 5);
      end else begin
         rsp_stall  <= 1'b0;
         stall_hold <= $urandom_range(0, 15);
      end
   end

   // Check each result transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Drop valid and wait until every expected result has come
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.expected_runs.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_policy(input bit sjf);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= sjf;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      board.shortest_first = sjf;
   endtask

   // Transfer one process, after an optional idle burst
   task automatic send_process(input logic [15:0] arr, input logic [15:0] bur,
                               input bit last);
      nlss_pkg::req_type item;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      item.arrival_time = arr;
      item.burst_time   = bur;
      item.last_process = last;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(item);
   endtask

   initial begin
      int          sent;
      int          size;
      int          mode;
      int          batch;
      logic [15:0] arr_v;
      logic [15:0] bur_v;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Last come first served: single process, equal arrivals, final jump
      write_policy(1'b0);
      send_process(16'd0, 16'd0, 1'b1);
      send_process(16'd5, 16'd3, 1'b0);
      send_process(16'd5, 16'd3, 1'b0);
      send_process(16'd0, 16'd10, 1'b0);
      send_process(16'hFFFF, 16'hFFFF, 1'b0);
      send_process(16'd2, 16'd0, 1'b1);

      // Shortest job first: burst ties broken by arrival, then by index
      write_policy(1'b1);
      send_process(16'd100, 16'd7, 1'b0);
      send_process(16'd100, 16'd7, 1'b0);
      send_process(16'd90, 16'd7, 1'b0);
      send_process(16'd0, 16'hFFFF, 1'b0);
      send_process(16'hFFFF, 16'd0, 1'b0);
      send_process(16'd3, 16'd0, 1'b1);
      send_process(16'd40, 16'd5, 1'b0);
      send_process(16'd10, 16'd9, 1'b1);
      write_policy(1'b0);

      // Random batches; two of them fill the table, one overflows it
      sent  = 0;
      batch = 0;
      while (sent < RANDOM_ITEMS) begin
         if (batch == 2) size = MAX_PROCS + $urandom_range(1, 5);
         else if (batch == 6) size = MAX_PROCS;
         else if ($urandom_range(0, 3) == 0) size = $urandom_range(13, 30);
         else size = $urandom_range(1, 12);
         mode = $urandom_range(0, 3);
         for (int j = 0; j < size; j++) begin
            case (mode)
               0: begin
                  arr_v = 16'($urandom_range(0, 40));
                  bur_v = 16'($urandom_range(0, 20));
               end
               1: begin
                  arr_v = 16'($urandom_range(0, 3000));
                  bur_v = 16'($urandom_range(0, 300));
               end
               2: begin
                  arr_v = 16'($urandom);
                  bur_v = 16'($urandom);
               end
               default: begin
                  arr_v = 16'($urandom_range(0, 3) * 7);
                  bur_v = 16'($urandom_range(0, 3));
               end
            endcase
            case ($urandom_range(0, 19))
               0: arr_v = 16'hFFFF;
               1: arr_v = 16'h0000;
               2: bur_v = 16'hFFFF;
               3: bur_v = 16'h0000;
               default: ;
            endcase
            quiet = (sent >= RANDOM_ITEMS - QUIET_ITEMS);
            send_process(arr_v, bur_v, j == size - 1);
            sent++;
         end
         batch++;
         if ($urandom_range(0, 2) == 0) write_policy(1'($urandom_range(0, 1)));
      end

      wait_idle();
      if (board.mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ===== nonpreemptive_lcfs_sjf_scheduler.f =====
design/nlss_pkg.sv
design/nlss_store.sv
design/nlss_pick.sv
design/nonpreemptive_lcfs_sjf_scheduler.sv
tb/nonpreemptive_lcfs_sjf_scheduler_test.sv
